/* rtl/spr_pkg.sv */
// ----------------------------------------------------------------------------
// spr_pkg
// Types, command codes, constants and a slot byte-size function shared by the slot pool block.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam logic [23:0] MAX_FRAMES     = 24'd8388608;
    localparam logic [3:0]  MAX_CHANNELS   = 4'd8;
    localparam int          SAMPLE_BYTES   = 4;
    localparam logic [15:0] REF_MAX        = 16'hFFFF;
    localparam logic [32:0] BARRIER_BLOCKS = 33'd2;

    localparam logic [3:0] FN_ACQUIRE = 4'd0;
    localparam logic [3:0] FN_SIZE    = 4'd1;
    localparam logic [3:0] FN_PUBLISH = 4'd2;
    localparam logic [3:0] FN_FAIL    = 4'd3;
    localparam logic [3:0] FN_CLEAR   = 4'd4;
    localparam logic [3:0] FN_ADDREF  = 4'd5;
    localparam logic [3:0] FN_RETIRE  = 4'd6;
    localparam logic [3:0] FN_COLLECT = 4'd7;
    localparam logic [3:0] FN_QUERY   = 4'd8;

    localparam logic [1:0] COND_EMPTY   = 2'd0;
    localparam logic [1:0] COND_LOADING = 2'd1;
    localparam logic [1:0] COND_READY   = 2'd2;
    localparam logic [1:0] COND_ERROR   = 2'd3;

    typedef struct packed {
        logic [3:0]  func;
        logic [3:0]  slot;
        logic [23:0] frames;
        logic [3:0]  channels;
        logic [31:0] block_now;
    } cmd_t;

    typedef struct packed {
        logic        status;
        logic [3:0]  slot_index;
        logic [7:0]  generation;
        logic [4:0]  ready_slots;
        logic [32:0] byte_sum;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  cond;
        logic [15:0] ref_cnt;
        logic        pending;
        logic [32:0] release_blk;
        logic [23:0] frames;
        logic [3:0]  channels;
        logic [7:0]  gen;
    } slot_rec_t;

    function automatic logic [32:0] slot_bytes(input logic [23:0] frames,
                                               input logic [3:0]  chans);
        logic [32:0] prod;
        prod = 33'(frames) * 33'(chans);
        return 33'(prod * 33'(SAMPLE_BYTES));
    endfunction

endpackage

/* rtl/spr_slot_ram.sv */
// ----------------------------------------------------------------------------
// spr_slot_ram
// Slot record memory: one write port, one registered read port. Entries
// never written since reset read as all zero.
// ----------------------------------------------------------------------------
module spr_slot_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  spr_pkg::slot_rec_t  wdata,
    input  logic [AW-1:0]       raddr,
    output spr_pkg::slot_rec_t  rdata
);
    import spr_pkg::*;

    slot_rec_t        mem [DEPTH];
    logic [DEPTH-1:0] written_reg;
    slot_rec_t        rd_reg;
    logic             rd_ok_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end else begin
            if (we) begin
                written_reg[waddr] <= 1'b1;
            end
            rd_ok_reg <= written_reg[raddr];
        end
    end

    assign rdata = rd_ok_reg ? rd_reg : '0;

endmodule

/* rtl/slot_pool_deferred_reclaim.sv */
// ----------------------------------------------------------------------------
// slot_pool_deferred_reclaim
// Reference-counted slot pool with deferred reclaim, slot records held in one RAM.
// ----------------------------------------------------------------------------
// One command in flight. Query, unknown or out-of-range commands go straight
// to the result; others visit their slot, acquire up to the first empty one,
// clear refs and collect every slot. A visit reads RAM, then may write back.
// Reset clears control state and marks every slot record unwritten, so all
// slots read as empty with zero fields; the pool is usable right after reset.
module slot_pool_deferred_reclaim #(
    parameter int MAX_SLOTS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  spr_pkg::cmd_t s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output spr_pkg::rsp_t m_payload
);
    import spr_pkg::*;

    localparam int AW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_EXEC, ST_FIN} state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [AW-1:0]     idx_reg;
    logic              status_reg;
    logic [3:0]        claimed_reg;
    logic [7:0]        gen_reg;
    logic [CNT_W-1:0]  loaded_reg;
    logic [32:0]       total_reg, total_next;
    logic [32:0]       sub_reg, add_reg;
    logic              m_valid_reg;
    rsp_t              m_payload_reg;

    slot_rec_t         rd_rec, wr_rec;
    logic              we_c, hit_c, stat_c, inc_c, dec_c;
    logic [32:0]       sub_c, add_c;
    logic              last_idx, scan_done, in_range, now_ge;

    spr_slot_ram #(.DEPTH(MAX_SLOTS), .AW(AW)) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (we_c),
        .waddr   (idx_reg),
        .wdata   (wr_rec),
        .raddr   (idx_reg),
        .rdata   (rd_rec)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_payload  = m_payload_reg;
    assign total_next = total_reg - sub_reg + add_reg;
    assign last_idx   = (idx_reg == AW'(MAX_SLOTS - 1));
    assign in_range   = (int'(s_payload.slot) < MAX_SLOTS);
    assign now_ge     = ({1'b0, cmd_reg.block_now} >= rd_rec.release_blk);

    // Read-modify-write of the record addressed by idx_reg
    always_comb begin
        wr_rec = rd_rec;
        we_c   = 1'b0;
        hit_c  = 1'b0;
        stat_c = 1'b0;
        inc_c  = 1'b0;
        dec_c  = 1'b0;
        sub_c  = '0;
        add_c  = '0;
        if (state_reg == ST_EXEC) begin
            case (cmd_reg.func)
                FN_ACQUIRE: begin
                    if (rd_rec.cond == COND_EMPTY) begin
                        wr_rec.cond        = COND_LOADING;
                        wr_rec.frames      = '0;
                        wr_rec.channels    = '0;
                        wr_rec.release_blk = '0;
                        wr_rec.pending     = 1'b0;
                        wr_rec.ref_cnt     = '0;
                        wr_rec.gen         = rd_rec.gen + 8'd1;
                        we_c  = 1'b1;
                        hit_c = 1'b1;
                    end
                end
                FN_SIZE: begin
                    if (cmd_reg.frames == '0 || cmd_reg.frames > MAX_FRAMES ||
                        cmd_reg.channels == '0 || cmd_reg.channels > MAX_CHANNELS ||
                        rd_rec.cond != COND_LOADING) begin
                        stat_c = 1'b1;
                    end else begin
                        sub_c           = slot_bytes(rd_rec.frames, rd_rec.channels);
                        add_c           = slot_bytes(cmd_reg.frames, cmd_reg.channels);
                        wr_rec.frames   = cmd_reg.frames;
                        wr_rec.channels = cmd_reg.channels;
                        we_c = 1'b1;
                    end
                end
                FN_PUBLISH, FN_FAIL: begin
                    wr_rec.cond = (cmd_reg.func == FN_PUBLISH) ? COND_READY : COND_ERROR;
                    inc_c = (cmd_reg.func == FN_PUBLISH);
                    dec_c = (rd_rec.cond == COND_READY);
                    we_c  = 1'b1;
                end
                FN_CLEAR: begin
                    wr_rec.ref_cnt = '0;
                    we_c = 1'b1;
                end
                FN_ADDREF: begin
                    if (rd_rec.ref_cnt != REF_MAX) begin
                        wr_rec.ref_cnt = rd_rec.ref_cnt + 16'd1;
                    end
                    we_c = 1'b1;
                end
                FN_RETIRE: begin
                    wr_rec.pending = 1'b1;
                    if (rd_rec.ref_cnt == '0 && rd_rec.cond == COND_READY) begin
                        wr_rec.release_blk = {1'b0, cmd_reg.block_now} + BARRIER_BLOCKS;
                        wr_rec.pending     = 1'b0;
                        wr_rec.cond        = COND_LOADING;
                        dec_c = 1'b1;
                    end
                    we_c = 1'b1;
                end
                FN_COLLECT: begin
                    // hide a pending slot first; it is not freed in this pass
                    if (rd_rec.pending && rd_rec.ref_cnt == '0 &&
                        rd_rec.cond == COND_READY) begin
                        wr_rec.release_blk = {1'b0, cmd_reg.block_now} + BARRIER_BLOCKS;
                        wr_rec.pending     = 1'b0;
                        wr_rec.cond        = COND_LOADING;
                        dec_c = 1'b1;
                        we_c  = 1'b1;
                    end else if (rd_rec.cond == COND_LOADING && rd_rec.release_blk != '0 &&
                                 now_ge && rd_rec.ref_cnt == '0) begin
                        sub_c              = slot_bytes(rd_rec.frames, rd_rec.channels);
                        wr_rec.frames      = '0;
                        wr_rec.channels    = '0;
                        wr_rec.release_blk = '0;
                        wr_rec.cond        = COND_EMPTY;
                        we_c = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cmd_reg.func)
            FN_ACQUIRE:           scan_done = hit_c || last_idx;
            FN_CLEAR, FN_COLLECT: scan_done = last_idx;
            default:              scan_done = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            loaded_reg  <= '0;
            total_reg   <= '0;
            sub_reg     <= '0;
            add_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            total_reg  <= total_next;
            sub_reg    <= sub_c;
            add_reg    <= add_c;
            loaded_reg <= loaded_reg + CNT_W'(inc_c) - CNT_W'(dec_c);
            if (state_reg == ST_FIN && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg     <= s_payload;
                        claimed_reg <= '0;
                        gen_reg     <= '0;
                        case (s_payload.func)
                            FN_ACQUIRE, FN_CLEAR, FN_COLLECT: begin
                                idx_reg    <= '0;
                                status_reg <= 1'b0;
                                state_reg  <= ST_RD;
                            end
                            FN_SIZE, FN_PUBLISH, FN_FAIL, FN_ADDREF, FN_RETIRE: begin
                                idx_reg    <= AW'(s_payload.slot);
                                status_reg <= !in_range;
                                state_reg  <= in_range ? ST_RD : ST_FIN;
                            end
                            FN_QUERY: begin
                                idx_reg    <= '0;
                                status_reg <= 1'b0;
                                state_reg  <= ST_FIN;
                            end
                            default: begin
                                idx_reg    <= '0;
                                status_reg <= 1'b1;
                                state_reg  <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_RD: begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (stat_c) begin
                        status_reg <= 1'b1;
                    end
                    if (cmd_reg.func == FN_ACQUIRE) begin
                        if (hit_c) begin
                            claimed_reg <= 4'(idx_reg);
                            gen_reg     <= wr_rec.gen;
                        end else if (last_idx) begin
                            status_reg <= 1'b1;
                        end
                    end
                    if (scan_done) begin
                        state_reg <= ST_FIN;
                    end else begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= ST_RD;
                    end
                end
                ST_FIN: begin
                    // hold until the result register is free
                    if (!m_valid_reg || m_ready) begin
                        m_payload_reg.status      <= status_reg;
                        m_payload_reg.slot_index  <= claimed_reg;
                        m_payload_reg.generation  <= gen_reg;
                        m_payload_reg.ready_slots <= 5'(loaded_reg);
                        m_payload_reg.byte_sum    <= total_next;
                        state_reg                 <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_loaded_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(loaded_reg) <= MAX_SLOTS)
        else $error("ready slot count exceeds pool size");

    a_write_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        we_c |-> state_reg == ST_EXEC)
        else $error("slot RAM written outside execute step");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second command taken while one is in flight");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule
